@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/kwm_pkg.sv @@
package kwm_pkg;

    localparam int RUN_W     = 3;
    localparam int VALUE_W   = 64;
    localparam int COUNT_W   = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 4;
    localparam int PC_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SORT_ORDER  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RUNS_IN_USE = 1'd1;

    localparam logic [PC_W-1:0] STEP_WAIT  = 3'd0;
    localparam logic [PC_W-1:0] STEP_CLEAR = 3'd1;
    localparam logic [PC_W-1:0] STEP_SCAN  = 3'd2;
    localparam logic [PC_W-1:0] STEP_LAST  = 3'd3;
    localparam logic [PC_W-1:0] STEP_EMIT  = 3'd4;

    typedef struct packed {
        logic [RUN_W-1:0]          run_index;
        logic signed [VALUE_W-1:0] record_value;
        logic                      run_done;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic [RUN_W-1:0]          source_run;
        logic                      end_of_merge;
    } out_item_t;

    typedef enum logic [1:0] {
        COND_NEVER,
        COND_NOT_START,
        COND_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic             take_in;
        logic             scan_clear;
        logic             scan_read;
        logic             scan_cmp;
        logic             emit;
        cond_t            cond;
        logic [PC_W-1:0]  jump_pc;
        logic [PC_W-1:0]  next_pc;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic more;
        logic out_busy;
    } status_t;

    // microcode: one control word per step
    function automatic ctrl_t ucode_word(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '{take_in: 1'b0, scan_clear: 1'b0, scan_read: 1'b0, scan_cmp: 1'b0,
              emit: 1'b0, cond: COND_NEVER, jump_pc: STEP_WAIT, next_pc: STEP_WAIT};
        case (pc)
            STEP_WAIT:
            begin
                w.take_in = 1'b1;
                w.cond    = COND_NOT_START;
                w.jump_pc = STEP_WAIT;
                w.next_pc = STEP_CLEAR;
            end
            STEP_CLEAR:
            begin
                w.scan_clear = 1'b1;
                w.next_pc    = STEP_SCAN;
            end
            STEP_SCAN:
            begin
                w.scan_read = 1'b1;
                w.scan_cmp  = 1'b1;
                w.cond      = COND_MORE;
                w.jump_pc   = STEP_SCAN;
                w.next_pc   = STEP_LAST;
            end
            STEP_LAST:
            begin
                w.scan_cmp = 1'b1;
                w.next_pc  = STEP_EMIT;
            end
            STEP_EMIT:
            begin
                w.emit    = 1'b1;
                w.cond    = COND_OUT_BUSY;
                w.jump_pc = STEP_EMIT;
                w.next_pc = STEP_WAIT;
            end
            default:
            begin
                w.next_pc = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

@@ rtl/kwm_sequencer.sv @@
module kwm_sequencer
    import kwm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctrl_t   ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            jump;

    assign ctrl = ucode_word(pc_reg);

    always_comb
    begin
        case (ctrl.cond)
            COND_NEVER:     jump = 1'b0;
            COND_NOT_START: jump = !status.start;
            COND_MORE:      jump = status.more;
            COND_OUT_BUSY:  jump = status.out_busy;
            default:        jump = 1'b0;
        endcase
        pc_next = jump ? ctrl.jump_pc : ctrl.next_pc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

@@ rtl/kwm_datapath.sv @@
module kwm_datapath
    import kwm_pkg::*;
#(
    parameter int MAX_RUNS     = 8,
    parameter int RECORD_WIDTH = 64,
    parameter int IDX_W        = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctrl_t                   ctrl,
    input  logic                    sort_order,
    input  logic [COUNT_W-1:0]      run_count,
    input  logic                    wr_en,
    input  logic [IDX_W-1:0]        wr_idx,
    input  logic                    wr_live,
    input  logic [RECORD_WIDTH-1:0] wr_value,
    input  logic                    clear_live,
    output logic                    more,
    output logic                    found,
    output logic [IDX_W-1:0]        best_idx,
    output logic [RECORD_WIDTH-1:0] best_value
);

    logic [RECORD_WIDTH-1:0] head_mem [MAX_RUNS];
    logic [MAX_RUNS-1:0]     live_reg;
    logic [IDX_W-1:0]        cnt_reg;
    logic [RECORD_WIDTH-1:0] rd_value_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic                    rd_live_reg;
    logic                    rd_valid_reg;
    logic                    found_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic [RECORD_WIDTH-1:0] best_value_reg;
    logic                    better;
    logic                    take;

    assign more = (32'(cnt_reg) + 32'd1) < 32'(run_count);

    always_comb
    begin
        if (sort_order)
            better = $signed(rd_value_reg) > $signed(best_value_reg);
        else
            better = $signed(rd_value_reg) < $signed(best_value_reg);
        take = ctrl.scan_cmp && rd_valid_reg && rd_live_reg && (!found_reg || better);
    end

    // head store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_live)
        begin
            head_mem[wr_idx] <= wr_value;
        end
        if (ctrl.scan_read)
        begin
            rd_value_reg <= head_mem[cnt_reg];
            rd_idx_reg   <= cnt_reg;
            rd_live_reg  <= live_reg[cnt_reg];
        end
        if (take)
        begin
            best_idx_reg   <= rd_idx_reg;
            best_value_reg <= rd_value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg     <= '0;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            if (clear_live)
                live_reg <= '0;
            else if (wr_en)
                live_reg[wr_idx] <= wr_live;

            if (ctrl.scan_clear)
            begin
                cnt_reg      <= '0;
                rd_valid_reg <= 1'b0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (ctrl.scan_read)
                begin
                    cnt_reg      <= cnt_reg + 1'b1;
                    rd_valid_reg <= 1'b1;
                end
                if (take)
                    found_reg <= 1'b1;
            end
        end
    end

    assign found      = found_reg;
    assign best_idx   = best_idx_reg;
    assign best_value = best_value_reg;

endmodule

@@ rtl/k_way_merge_heap.sv @@
// K-way merge of sorted runs. Configure sort_order and runs_in_use while idle, then send one
// head record per run in run order 0, 1, 2, ... (run_done marks an empty run). Each
// result carries the winning head and the run to refill; send exactly that run's next
// record or its done mark. Items for any other run are dropped. When all
// runs are done an end_of_merge transaction (value and run zero) is sent and the block
// returns to collecting heads. After an item that produces a result is accepted, a
// microcoded sequencer scans the head store one entry per cycle through its single read
// port, then the winner is loaded into the result register.
// A finished result waits in the output register without blocking the next input.
module k_way_merge_heap
    import kwm_pkg::*;
#(
    parameter int MAX_RUNS     = 8,
    parameter int RECORD_WIDTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_item
);

`include "assert_macros.svh"

    localparam int IDX_W = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;

    typedef enum logic {
        PHASE_FILL,
        PHASE_MERGE
    } phase_t;

    ctrl_t                   ctrl;
    status_t                 status;
    logic                    sort_order_reg;
    logic [COUNT_W-1:0]      runs_reg;
    phase_t                  phase_reg;
    logic [COUNT_W-1:0]      heads_reg;
    logic [RUN_W-1:0]        awaited_reg;
    logic                    out_valid_reg;
    out_item_t               out_reg;
    logic [COUNT_W-1:0]      run_count;
    logic                    accept;
    logic                    run_ok;
    logic                    fill_take;
    logic                    merge_take;
    logic [COUNT_W-1:0]      heads_after;
    logic                    fill_done;
    logic                    out_busy;
    logic                    emit_commit;
    logic                    scan_more;
    logic                    found;
    logic [IDX_W-1:0]        best_idx;
    logic [RECORD_WIDTH-1:0] best_value;
    logic                    wr_en;

    always_comb
    begin
        if (runs_reg == '0)
            run_count = COUNT_W'(1);
        else if (32'(runs_reg) > MAX_RUNS)
            run_count = COUNT_W'(MAX_RUNS);
        else
            run_count = runs_reg;

        accept     = in_valid && ctrl.take_in;
        run_ok     = 32'(in_item.run_index) < MAX_RUNS;
        fill_take  = (COUNT_W'(in_item.run_index) == heads_reg)
                     && (COUNT_W'(in_item.run_index) < run_count) && run_ok;
        merge_take = (in_item.run_index == awaited_reg) && run_ok;
        heads_after = fill_take ? heads_reg + 1'b1 : heads_reg;
        fill_done  = heads_after >= run_count;

        if (phase_reg == PHASE_FILL)
        begin
            wr_en        = accept && fill_take;
            status.start = accept && fill_done;
        end
        else
        begin
            wr_en        = accept && merge_take;
            status.start = accept && merge_take;
        end

        out_busy        = out_valid_reg && out_stall;
        emit_commit     = ctrl.emit && !out_busy;
        status.out_busy = out_busy;
        status.more     = scan_more;
    end

    assign in_stall  = !ctrl.take_in;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    kwm_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    kwm_datapath #(
        .MAX_RUNS     (MAX_RUNS),
        .RECORD_WIDTH (RECORD_WIDTH),
        .IDX_W        (IDX_W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .sort_order (sort_order_reg),
        .run_count  (run_count),
        .wr_en      (wr_en),
        .wr_idx     (IDX_W'(in_item.run_index)),
        .wr_live    (!in_item.run_done),
        .wr_value   (in_item.record_value[RECORD_WIDTH-1:0]),
        .clear_live (emit_commit && !found),
        .more       (scan_more),
        .found      (found),
        .best_idx   (best_idx),
        .best_value (best_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_order_reg <= 1'b0;
            runs_reg       <= COUNT_W'(8);
            phase_reg      <= PHASE_FILL;
            heads_reg      <= '0;
            awaited_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SORT_ORDER:  sort_order_reg <= cfg_data[0];
                    REG_RUNS_IN_USE: runs_reg       <= cfg_data;
                    default:         ;
                endcase
            end

            if (accept && (phase_reg == PHASE_FILL))
            begin
                heads_reg <= heads_after;
                if (fill_done)
                    phase_reg <= PHASE_MERGE;
            end

            if (emit_commit)
            begin
                out_valid_reg <= 1'b1;
                if (found)
                begin
                    out_reg.out_value    <= VALUE_W'($signed(best_value));
                    out_reg.source_run   <= RUN_W'(best_idx);
                    out_reg.end_of_merge <= 1'b0;
                    awaited_reg          <= RUN_W'(best_idx);
                end
                else
                begin
                    out_reg.out_value    <= '0;
                    out_reg.source_run   <= '0;
                    out_reg.end_of_merge <= 1'b1;
                    awaited_reg          <= '0;
                    heads_reg            <= '0;
                    phase_reg            <= PHASE_FILL;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `ASSERT_IMPLIES(a_end_marker_empty, clk, rst_n,
        out_valid_reg && out_reg.end_of_merge,
        (out_reg.out_value == '0) && (out_reg.source_run == '0))
    `ASSERT_NEXT(a_refill_target, clk, rst_n,
        emit_commit && found,
        awaited_reg == out_reg.source_run)
    `ASSERT_NEXT(a_end_restarts_fill, clk, rst_n,
        emit_commit && !found,
        (phase_reg == PHASE_FILL) && (heads_reg == '0))

endmodule

@@ tb/sv/kwm_merge_checker.sv @@
`timescale 1ns / 1ps

module kwm_merge_checker
    import kwm_pkg::*;
#(
    parameter int MAX_RUNS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  in_item_t             in_item,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  out_item_t            out_item,
    output int                   errors,
    output int                   pending,
    output int                   checked,
    output int                   end_markers
);

    typedef logic signed [VALUE_W-1:0] rec_t;

    logic               descending;
    logic [COUNT_W-1:0] run_count;
    rec_t               head_val [MAX_RUNS];
    logic               head_live [MAX_RUNS];
    int                 heads_in;
    logic [RUN_W-1:0]   refill_run;
    logic               merging;

    out_item_t          merged_q [$];
    out_item_t          want;
    out_item_t          got;

    function automatic int active_runs();
        if (run_count == 0)
            return 1;
        if (run_count > MAX_RUNS)
            return MAX_RUNS;
        return int'(run_count);
    endfunction

    // winner among live heads, or the end marker when none is left
    function automatic out_item_t pick_winner();
        bit   found;
        int   best;
        rec_t best_val;
        found    = 1'b0;
        best     = 0;
        best_val = '0;
        for (int i = 0; i < active_runs(); i++)
        begin
            if (head_live[i] &&
                (!found || (descending ? head_val[i] > best_val : head_val[i] < best_val)))
            begin
                found    = 1'b1;
                best     = i;
                best_val = head_val[i];
            end
        end
        if (!found)
        begin
            for (int i = 0; i < MAX_RUNS; i++)
                head_live[i] = 1'b0;
            heads_in   = 0;
            refill_run = '0;
            merging    = 1'b0;
            return '{out_value: '0, source_run: '0, end_of_merge: 1'b1};
        end
        refill_run = RUN_W'(best);
        return '{out_value: best_val, source_run: RUN_W'(best), end_of_merge: 1'b0};
    endfunction

    function automatic bit merge_step(input in_item_t it, output out_item_t res);
        int run;
        run = int'(it.run_index);
        res = '0;
        if (!merging)
        begin
            if (run == heads_in && run < active_runs())
            begin
                head_live[run] = !it.run_done;
                if (!it.run_done)
                    head_val[run] = it.record_value;
                heads_in++;
            end
            if (heads_in >= active_runs())
            begin
                merging = 1'b1;
                res     = pick_winner();
                return 1'b1;
            end
            return 1'b0;
        end
        if (it.run_index != refill_run)
            return 1'b0;
        head_live[run] = !it.run_done;
        if (!it.run_done)
            head_val[run] = it.record_value;
        res = pick_winner();
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            descending  = 1'b0;
            run_count   = COUNT_W'(8);
            for (int i = 0; i < MAX_RUNS; i++)
            begin
                head_val[i]  = '0;
                head_live[i] = 1'b0;
            end
            heads_in    = 0;
            refill_run  = '0;
            merging     = 1'b0;
            merged_q.delete();
            errors      = 0;
            pending     = 0;
            checked     = 0;
            end_markers = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (merged_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual value %0d run %0d end %0b",
                             $time, out_item.out_value, out_item.source_run,
                             out_item.end_of_merge);
                end
                else
                begin
                    want = merged_q.pop_front();
                    checked++;
                    if (want.end_of_merge)
                        end_markers++;
                    if (out_item.out_value !== want.out_value)
                    begin
                        errors++;
                        $display("%0t: out_value expected %0d actual %0d",
                                 $time, want.out_value, out_item.out_value);
                    end
                    if (out_item.source_run !== want.source_run)
                    begin
                        errors++;
                        $display("%0t: source_run expected %0d actual %0d",
                                 $time, want.source_run, out_item.source_run);
                    end
                    if (out_item.end_of_merge !== want.end_of_merge)
                    begin
                        errors++;
                        $display("%0t: end_of_merge expected %0b actual %0b",
                                 $time, want.end_of_merge, out_item.end_of_merge);
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SORT_ORDER:  descending = cfg_data[0];
                    REG_RUNS_IN_USE: run_count  = cfg_data;
                    default:         ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (merge_step(in_item, got))
                    merged_q.push_back(got);
            end
            pending = merged_q.size();
        end
    end

endmodule

@@ tb/sv/tb_k_way_merge_heap.sv @@
`timescale 1ns / 1ps

module tb_k_way_merge_heap;
    import kwm_pkg::*;

    typedef logic signed [VALUE_W-1:0] rec_t;

    localparam int   RUN_SLOTS   = 8;
    localparam int   CYCLE_LIMIT = 600000;
    localparam int   ITEM_TARGET = 700;
    localparam rec_t REC_MIN     = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam rec_t REC_MAX     = {1'b0, {(VALUE_W-1){1'b1}}};

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_item;
    logic                 out_valid;
    logic                 out_stall;
    out_item_t            out_item;

    int errors;
    int pending;
    int checked;
    int end_markers;

    int        cycles;
    int        fed_items;
    int        noise_items;
    int        merges;
    int        noise_pct;
    int        stall_len;
    bit        calm;
    bit        order_sel;
    int        runs_sel;
    rec_t      run_data [RUN_SLOTS][$];
    out_item_t emitted_q [$];

    k_way_merge_heap dut (.*);

    kwm_merge_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Run did not complete within %0d cycles", CYCLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            emitted_q.push_back(out_item);
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic rec_t rand_record();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return {$urandom, $urandom};
            4, 5, 6:    return rec_t'($signed($urandom_range(0, 16)) - 8);
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       return REC_MIN;
                    1:       return REC_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default:    return rec_t'($signed({$urandom, $urandom}) >>> $urandom_range(8, 56));
        endcase
    endfunction

    function automatic int active_count();
        if (runs_sel < 1)
            return 1;
        if (runs_sel > RUN_SLOTS)
            return RUN_SLOTS;
        return runs_sel;
    endfunction

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            repeat ($urandom_range(1, 6)) @(negedge clk);
            stall_len = pick_gap();
            if (stall_len > 0)
            begin
                out_stall = 1'b1;
                repeat (stall_len) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    task automatic send_item(input logic [RUN_W-1:0] run, input rec_t value, input logic done);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  = '{run_index: run, record_value: value, run_done: done};
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        fed_items++;
        @(negedge clk);
    endtask

    // transaction for a run the block is not waiting on
    task automatic send_noise(input logic [RUN_W-1:0] avoid);
        logic [RUN_W-1:0] r;
        r = RUN_W'($urandom_range(0, RUN_SLOTS - 1));
        if (r == avoid)
            r = r + 1'b1;
        noise_items++;
        send_item(r, rand_record(), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_refill(input logic [RUN_W-1:0] run);
        if (run_data[run].size() > 0)
            send_item(run, run_data[run].pop_front(), 1'b0);
        else
            send_item(run, rand_record(), 1'b1);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == REG_SORT_ORDER)
            order_sel = data[0];
        else
            runs_sel = int'(data);
    endtask

    task automatic build_runs(input int n, input int max_len, input bit sorted);
        for (int i = 0; i < RUN_SLOTS; i++)
        begin
            run_data[i].delete();
            if (i < n)
            begin
                repeat ($urandom_range(0, max_len))
                    run_data[i].push_back(rand_record());
                if (sorted)
                begin
                    if (order_sel)
                        run_data[i].rsort();
                    else
                        run_data[i].sort();
                end
            end
        end
    endtask

    task automatic fill_heads(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_noise(RUN_W'(i));
            send_refill(RUN_W'(i));
        end
    endtask

    task automatic drain_results();
        out_item_t res;
        forever
        begin
            if (emitted_q.size() == 0)
            begin
                in_valid = 1'b0;
                while (emitted_q.size() == 0)
                    @(negedge clk);
            end
            res = emitted_q.pop_front();
            if (res.end_of_merge)
            begin
                merges++;
                break;
            end
            if ($urandom_range(0, 99) < noise_pct)
                send_noise(res.source_run);
            send_refill(res.source_run);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_SORT_ORDER;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_item   = '0;
        calm      = 1'b0;
        order_sel = 1'b0;
        runs_sel  = 8;
        noise_pct = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // two runs, ties at both extremes, one out-of-order head dropped
        set_reg(REG_SORT_ORDER, CFG_DAT_W'(0));
        set_reg(REG_RUNS_IN_USE, CFG_DAT_W'(2));
        build_runs(RUN_SLOTS, 0, 1'b1);
        run_data[0] = '{REC_MIN, rec_t'(0), REC_MAX};
        run_data[1] = '{REC_MIN, rec_t'(-1), REC_MAX};
        send_noise(RUN_W'(0));
        fill_heads(2);
        drain_results();

        // descending, run count zero acts as one run
        set_reg(REG_SORT_ORDER, CFG_DAT_W'(1));
        set_reg(REG_RUNS_IN_USE, CFG_DAT_W'(0));
        build_runs(RUN_SLOTS, 0, 1'b1);
        run_data[0] = '{REC_MAX, rec_t'(5)};
        fill_heads(1);
        drain_results();

        // run count above the maximum, only the last run has data
        set_reg(REG_SORT_ORDER, CFG_DAT_W'(0));
        set_reg(REG_RUNS_IN_USE, CFG_DAT_W'(15));
        build_runs(RUN_SLOTS, 0, 1'b1);
        run_data[7] = '{rec_t'(-3)};
        noise_pct = 30;
        fill_heads(RUN_SLOTS);
        drain_results();
        noise_pct = 0;

        // run count lowered during fill: the next transaction of any run starts the merge
        set_reg(REG_RUNS_IN_USE, CFG_DAT_W'(8));
        build_runs(RUN_SLOTS, 0, 1'b1);
        send_item(RUN_W'(0), rec_t'(10), 1'b0);
        send_item(RUN_W'(1), rec_t'(10), 1'b0);
        send_item(RUN_W'(2), rec_t'(4), 1'b0);
        set_reg(REG_RUNS_IN_USE, CFG_DAT_W'(2));
        send_item(RUN_W'(6), rand_record(), 1'b0);
        drain_results();

        while (fed_items - noise_items < ITEM_TARGET)
        begin
            if ($urandom_range(0, 2) == 0)
                set_reg(REG_SORT_ORDER, CFG_DAT_W'($urandom_range(0, 1)));
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 9))
                    0:       set_reg(REG_RUNS_IN_USE, CFG_DAT_W'(0));
                    1:       set_reg(REG_RUNS_IN_USE, CFG_DAT_W'($urandom_range(9, 15)));
                    2, 3:    set_reg(REG_RUNS_IN_USE, CFG_DAT_W'(8));
                    default: set_reg(REG_RUNS_IN_USE, CFG_DAT_W'($urandom_range(1, 8)));
                endcase
            end
            calm      = ($urandom_range(0, 4) == 0);
            noise_pct = ($urandom_range(0, 2) == 0) ? 0 : 12;
            build_runs(active_count(), ($urandom_range(0, 7) == 0) ? 20 : 6,
                       $urandom_range(0, 9) != 0);
            fill_heads(active_count());
            drain_results();
        end

        in_valid = 1'b0;
        calm     = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("Fed %0d transactions (%0d for runs not being awaited) across %0d merges,",
                 fed_items, noise_items, merges);
        $display("both sort orders and run counts 0..15; %0d results checked, %0d end markers.",
                 checked, end_markers);
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
